FILE: hw/rtl/bvcp_pkg.sv
// Package with widths and the fixed discharge curve tables of the charge converter.
package bvcp_pkg;

  localparam int VOLT_W   = 13;
  localparam int CP_W     = 14;
  localparam int SLOTS    = 16;
  localparam int SEGS     = SLOTS - 1;
  localparam int SEG_W    = 4;
  localparam int DIFF_W   = VOLT_W;
  localparam int PROD_W   = DIFF_W + CP_W;
  localparam int RECIP_SH = 28;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int MUL_W    = PROD_W + RECIP_W;
  localparam int QUO_W    = CP_W;

  localparam int          DEF_CURVE_POINTS = 11;
  localparam logic [VOLT_W-1:0] DEF_CUTOFF_MV = 13'd3300;
  localparam logic [CP_W-1:0]   FULL_CHARGE   = 14'd10000;
  localparam logic [63:0]       RECIP_ONE     = 64'd1 << RECIP_SH;

  // Curve points, highest voltage first. Unused slots repeat the bottom point.
  localparam logic [VOLT_W-1:0] CURVE_MV [SLOTS] = '{
    13'd4200, 13'd4050, 13'd3960, 13'd3900, 13'd3850, 13'd3800, 13'd3760, 13'd3730,
    13'd3700, 13'd3650, 13'd3200, 13'd3200, 13'd3200, 13'd3200, 13'd3200, 13'd3200
  };

  localparam logic [CP_W-1:0] CURVE_CP [SLOTS] = '{
    14'd10000, 14'd9000, 14'd8000, 14'd7000, 14'd6000, 14'd5000, 14'd4000, 14'd3000,
    14'd2000, 14'd1000, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0
  };

  // Voltage span of each segment. Flat padding segments are never selected,
  // so their span is set to one to keep the reciprocal defined.
  localparam logic [VOLT_W-1:0] SEG_SPAN [SEGS] = '{
    13'd150, 13'd90, 13'd60, 13'd50, 13'd50, 13'd40, 13'd30, 13'd30,
    13'd50, 13'd450, 13'd1, 13'd1, 13'd1, 13'd1, 13'd1
  };

  // Charge rise across each segment.
  localparam logic [CP_W-1:0] SEG_DC [SEGS] = '{
    14'd1000, 14'd1000, 14'd1000, 14'd1000, 14'd1000, 14'd1000, 14'd1000, 14'd1000,
    14'd1000, 14'd1000, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0
  };

  // Truncated reciprocal of each span, scaled by two to the RECIP_SH.
  localparam logic [RECIP_W-1:0] SEG_RECIP [SEGS] = '{
    RECIP_W'(RECIP_ONE / 64'd150), RECIP_W'(RECIP_ONE / 64'd90),
    RECIP_W'(RECIP_ONE / 64'd60),  RECIP_W'(RECIP_ONE / 64'd50),
    RECIP_W'(RECIP_ONE / 64'd50),  RECIP_W'(RECIP_ONE / 64'd40),
    RECIP_W'(RECIP_ONE / 64'd30),  RECIP_W'(RECIP_ONE / 64'd30),
    RECIP_W'(RECIP_ONE / 64'd50),  RECIP_W'(RECIP_ONE / 64'd450),
    RECIP_W'(RECIP_ONE / 64'd1),   RECIP_W'(RECIP_ONE / 64'd1),
    RECIP_W'(RECIP_ONE / 64'd1),   RECIP_W'(RECIP_ONE / 64'd1),
    RECIP_W'(RECIP_ONE / 64'd1)
  };

endpackage

FILE: hw/rtl/bvcp_if.sv
// Handshake interfaces for the voltage, result and cutoff channels of the charge converter.
interface bvcp_in_if;
  logic                          valid;
  logic                          ready;
  logic [bvcp_pkg::VOLT_W-1:0]   batt_mv;
  modport source (output valid, output batt_mv, input ready);
  modport sink   (input valid, input batt_mv, output ready);
endinterface

interface bvcp_out_if;
  logic                          valid;
  logic                          ready;
  logic [bvcp_pkg::CP_W-1:0]     charge_centipct;
  logic                          safe_flag;
  modport source (output valid, output charge_centipct, output safe_flag, input ready);
  modport sink   (input valid, input charge_centipct, input safe_flag, output ready);
endinterface

interface bvcp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bvcp_pkg::VOLT_W-1:0]   low_cutoff_mv;
  modport source (output valid, output low_cutoff_mv, input ready);
  modport sink   (input valid, input low_cutoff_mv, output ready);
endinterface

FILE: hw/rtl/battery_voltage_to_charge_percent_core.sv
// Top level of the battery voltage to state-of-charge converter.
// The block turns a battery voltage in millivolts into a state of charge in
// hundredths of a percent along a fixed lithium-polymer discharge curve, with
// linear interpolation inside the bracketing segment and truncation of the
// result. At or above the top point the result is 10000, at or below the
// bottom point it is the bottom point's charge (0 for the full curve). A safe
// flag reports whether the voltage is at or above the programmable cutoff,
// which resets to 3300 mV and may be rewritten only while the block is idle.
// The block is a six-stage pipeline: while the result side does not stall, one
// voltage is accepted every cycle, and its result is offered on the output from
// the register of the sixth stage. The depth is set by the interpolation
// divide, done as a multiply by a per-segment reciprocal, a back-multiply and
// a one-step correction, with a register after each multiplier. Each stage
// holds its item while the stage after it is full and held, so a stall on the result
// side fills the empty stages first and only then holds off the input.
module battery_voltage_to_charge_percent_core #(
  parameter int CURVE_POINTS = bvcp_pkg::DEF_CURVE_POINTS
) (
  input  logic              clk,
  input  logic              rst_n,
  bvcp_in_if.sink           in_ch,
  bvcp_out_if.source        out_ch,
  bvcp_cfg_if.sink          cfg_ch
);
  import bvcp_pkg::*;

  localparam int NPTS = (CURVE_POINTS < 2) ? 2 : ((CURVE_POINTS > SLOTS) ? SLOTS : CURVE_POINTS);
  localparam int NSTG = 6;
  localparam logic [SEG_W-1:0] BOT_IDX = SEG_W'(NPTS - 1);

  // Cutoff register; every write transfer is taken at once.
  logic [VOLT_W-1:0] cutoff_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= DEF_CUTOFF_MV;
    end else if (cfg_ch.valid) begin
      cutoff_r <= cfg_ch.low_cutoff_mv;
    end
  end

  // Pipeline flow control. A stage loads when it is empty or its item moves on.
  logic [NSTG:1] vld_r;
  logic [NSTG+1:1] take;

  always_comb begin
    take[NSTG+1] = out_ch.ready;
    for (int k = NSTG; k >= 1; k--) begin
      take[k] = !vld_r[k] || take[k+1];
    end
  end

  assign in_ch.ready = take[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (take[1]) begin
        vld_r[1] <= in_ch.valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (take[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: segment search over the curve points and the cutoff compare.
  // The first segment from the top whose lower point lies at or below the
  // voltage brackets it, since every point above that one is higher still.
  logic [SEG_W-1:0]  seg_nxt;
  logic              hi_nxt;
  logic              lo_nxt;
  logic [VOLT_W-1:0] s1_volt_r;
  logic [SEG_W-1:0]  s1_seg_r;
  logic              s1_hi_r;
  logic              s1_lo_r;
  logic              s1_safe_r;

  always_comb begin
    seg_nxt = '0;
    for (int i = SEGS - 1; i >= 0; i--) begin
      if ((i <= NPTS - 2) && (in_ch.batt_mv >= CURVE_MV[i+1])) begin
        seg_nxt = SEG_W'(i);
      end
    end
    hi_nxt = in_ch.batt_mv >= CURVE_MV[0];
    lo_nxt = !hi_nxt && (in_ch.batt_mv <= CURVE_MV[BOT_IDX]);
  end

  always_ff @(posedge clk) begin
    if (take[1]) begin
      s1_volt_r <= in_ch.batt_mv;
      s1_seg_r  <= seg_nxt;
      s1_hi_r   <= hi_nxt;
      s1_lo_r   <= lo_nxt;
      s1_safe_r <= in_ch.batt_mv >= cutoff_r;
    end
  end

  // Stage 2: segment lookup. A clamped voltage gets its fixed charge as the
  // base with a zero offset, so the later stages add nothing to it.
  logic [CP_W-1:0]   s2_base_r;
  logic [DIFF_W-1:0] s2_diff_r;
  logic [CP_W-1:0]   s2_dc_r;
  logic [SEG_W-1:0]  s2_seg_r;
  logic              s2_safe_r;
  logic [SEG_W-1:0]  lo_idx;

  assign lo_idx = SEG_W'(s1_seg_r + 4'd1);

  always_ff @(posedge clk) begin
    if (take[2]) begin
      s2_seg_r  <= s1_seg_r;
      s2_safe_r <= s1_safe_r;
      if (s1_hi_r) begin
        s2_base_r <= CURVE_CP[0];
        s2_diff_r <= '0;
        s2_dc_r   <= '0;
      end else if (s1_lo_r) begin
        s2_base_r <= CURVE_CP[BOT_IDX];
        s2_diff_r <= '0;
        s2_dc_r   <= '0;
      end else begin
        s2_base_r <= CURVE_CP[lo_idx];
        s2_diff_r <= s1_volt_r - CURVE_MV[lo_idx];
        s2_dc_r   <= SEG_DC[s1_seg_r];
      end
    end
  end

  // Stage 3: offset times charge rise.
  logic [PROD_W-1:0] s3_prod_r;
  logic [CP_W-1:0]   s3_base_r;
  logic [SEG_W-1:0]  s3_seg_r;
  logic              s3_safe_r;

  always_ff @(posedge clk) begin
    if (take[3]) begin
      s3_prod_r <= PROD_W'(s2_diff_r) * PROD_W'(s2_dc_r);
      s3_base_r <= s2_base_r;
      s3_seg_r  <= s2_seg_r;
      s3_safe_r <= s2_safe_r;
    end
  end

  // Stage 4: quotient estimate by the span's reciprocal. The estimate is the
  // true quotient or one below it.
  logic [MUL_W-1:0]  s4_mul_r;
  logic [PROD_W-1:0] s4_prod_r;
  logic [CP_W-1:0]   s4_base_r;
  logic [SEG_W-1:0]  s4_seg_r;
  logic              s4_safe_r;

  always_ff @(posedge clk) begin
    if (take[4]) begin
      s4_mul_r  <= MUL_W'(s3_prod_r) * MUL_W'(SEG_RECIP[s3_seg_r]);
      s4_prod_r <= s3_prod_r;
      s4_base_r <= s3_base_r;
      s4_seg_r  <= s3_seg_r;
      s4_safe_r <= s3_safe_r;
    end
  end

  // Stage 5: back-multiply the estimate by the span.
  logic [QUO_W-1:0]  quo_est;
  logic [QUO_W-1:0]  s5_quo_r;
  logic [PROD_W-1:0] s5_back_r;
  logic [PROD_W-1:0] s5_prod_r;
  logic [CP_W-1:0]   s5_base_r;
  logic [SEG_W-1:0]  s5_seg_r;
  logic              s5_safe_r;

  assign quo_est = s4_mul_r[RECIP_SH +: QUO_W];

  always_ff @(posedge clk) begin
    if (take[5]) begin
      s5_quo_r  <= quo_est;
      s5_back_r <= PROD_W'(quo_est) * PROD_W'(SEG_SPAN[s4_seg_r]);
      s5_prod_r <= s4_prod_r;
      s5_base_r <= s4_base_r;
      s5_seg_r  <= s4_seg_r;
      s5_safe_r <= s4_safe_r;
    end
  end

  // Stage 6: bump the estimate when the remainder reaches the span, then add
  // the segment's base charge into the output register.
  logic [PROD_W-1:0] rem;
  logic [QUO_W-1:0]  quo_fix;
  logic [CP_W-1:0]   s6_charge_r;
  logic              s6_safe_r;

  assign rem     = s5_prod_r - s5_back_r;
  assign quo_fix = (rem >= PROD_W'(SEG_SPAN[s5_seg_r])) ? QUO_W'(s5_quo_r + 14'd1) : s5_quo_r;

  always_ff @(posedge clk) begin
    if (take[6]) begin
      s6_charge_r <= CP_W'(s5_base_r + quo_fix);
      s6_safe_r   <= s5_safe_r;
    end
  end

  assign out_ch.valid           = vld_r[NSTG];
  assign out_ch.charge_centipct = s6_charge_r;
  assign out_ch.safe_flag       = s6_safe_r;

  // A result never goes past full charge.
  a_charge_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG] |-> (s6_charge_r <= FULL_CHARGE))
    else $error("charge result above full scale");

  // The reciprocal estimate is at most one below the true quotient.
  a_quo_close: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (rem < (PROD_W'(SEG_SPAN[s5_seg_r]) << 1)))
    else $error("quotient estimate off by more than one");

  // With the output stage free the input is never held off.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NSTG] |-> in_ch.ready)
    else $error("input stalled while output stage is empty");

  // An item in the output stage that is not taken stays there.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG] && !out_ch.ready) |=> (vld_r[NSTG] && $stable(s6_charge_r)))
    else $error("stalled result lost or changed");

endmodule
